@@ hdl/sd_spi_data_block_receiver_defines.svh @@
// ---------------------------------------------------------------------------
// sd_spi_data_block_receiver_defines
// assertion macros shared by the receiver modules
// ---------------------------------------------------------------------------
`ifndef SD_SPI_DATA_BLOCK_RECEIVER_DEFINES_SVH
`define SD_SPI_DATA_BLOCK_RECEIVER_DEFINES_SVH

// same-cycle implication
`define SDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/sdr_pkg.sv @@
// ---------------------------------------------------------------------------
// sdr_pkg
// shared types and codes of the sd spi data block receiver
// ---------------------------------------------------------------------------
package sdr_pkg;

    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int LEN_W           = 13;
    localparam int POLL_W          = 8;
    localparam int CFG_IDX_W       = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NORESP = 3'd1;
    localparam logic [2:0] ST_LOCKED = 3'd2;
    localparam logic [2:0] ST_PARAM  = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_CRC    = 3'd5;
    localparam logic [2:0] ST_BUS    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 2'd1;

    localparam logic [7:0] START_TOKEN    = 8'hFE;
    localparam logic [7:0] TOKEN_LOW_MASK = 8'h1F;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       bus_error;
        logic       is_token;
        logic       is_err_token;
        logic [2:0] err_status;
    } sdr_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]  block_length;
        logic [POLL_W-1:0] poll_limit;
    } sdr_cfg_t;

endpackage

@@ hdl/sdr_front.sv @@
// ---------------------------------------------------------------------------
// sdr_front
// accepts input items, decodes tokens and queues them for the back end
// ---------------------------------------------------------------------------
`include "sd_spi_data_block_receiver_defines.svh"

module sdr_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // rx_byte[7:0], bus_error[8], zero fill
    input  logic              s_tuser,   // op
    output logic              q_valid,
    input  logic              q_ready,
    output sdr_pkg::sdr_item_t q_item
);
    import sdr_pkg::*;

    sdr_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    sdr_item_t  item_in;
    logic       push;
    logic       pop;

    // token decode
    always_comb
    begin
        item_in.op           = s_tuser;
        item_in.rx_byte      = s_tdata[7:0];
        item_in.bus_error    = s_tdata[8];
        item_in.is_token     = (s_tdata[7:0] == START_TOKEN);
        item_in.is_err_token = ((s_tdata[7:0] & ~TOKEN_LOW_MASK) == 8'h00);
        if (s_tdata[4])
            item_in.err_status = ST_LOCKED;
        else if (s_tdata[3])
            item_in.err_status = ST_PARAM;
        else
            item_in.err_status = ST_READ;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

    `SDR_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 2'd1)
    `SDR_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 2'd1)
    `SDR_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= 2'd2)

endmodule

@@ hdl/sdr_back.sv @@
// ---------------------------------------------------------------------------
// sdr_back
// read sequencer: token poll, payload with crc-16, crc check, status out
// ---------------------------------------------------------------------------
`include "sd_spi_data_block_receiver_defines.svh"

module sdr_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  sdr_pkg::sdr_cfg_t  cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  sdr_pkg::sdr_item_t q_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // payload_byte[7:0], status[10:8], zero fill
    output logic               m_tlast    // last
);
    import sdr_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_POLL   = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_CRC_HI = 3'd3;
    localparam logic [2:0] PH_CRC_LO = 3'd4;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [2:0]        phase_reg;
    logic [2:0]        phase_next;
    logic [POLL_W-1:0] poll_count_reg;
    logic [POLL_W-1:0] poll_count_next;
    logic [LEN_W-1:0]  bytes_left_reg;
    logic [LEN_W-1:0]  bytes_left_next;
    logic [15:0]       crc_reg;
    logic [15:0]       crc_next;
    logic [7:0]        crc_high_reg;
    logic [7:0]        crc_high_next;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [2:0]        out_status_reg;
    logic              out_last_reg;

    logic              pop;
    logic              res_valid;
    logic [7:0]        res_byte;
    logic [2:0]        res_status;
    logic              res_last;
    logic [LEN_W-1:0]  len_eff;
    logic [POLL_W-1:0] limit_eff;
    logic [POLL_W-1:0] poll_inc;
    logic [LEN_W-1:0]  bytes_dec;

    assign q_ready = !out_valid_reg || m_tready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        if (cfg.block_length == '0)
            len_eff = LEN_W'(1);
        else if (cfg.block_length > LEN_W'(MAX_BLOCK_BYTES))
            len_eff = LEN_W'(MAX_BLOCK_BYTES);
        else
            len_eff = cfg.block_length;
        limit_eff = (cfg.poll_limit == '0) ? POLL_W'(1) : cfg.poll_limit;
        poll_inc  = poll_count_reg + POLL_W'(1);
        bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - LEN_W'(1) : bytes_left_reg;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        poll_count_next = poll_count_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        res_valid       = 1'b0;
        res_byte        = 8'h00;
        res_status      = ST_OK;
        res_last        = 1'b0;
        if (pop)
        begin
            if (q_item.op == OP_START)
            begin
                phase_next      = PH_POLL;
                poll_count_next = '0;
                bytes_left_next = len_eff;
                crc_next        = 16'h0000;
                crc_high_next   = 8'h00;
            end
            else if (phase_reg inside {PH_POLL, PH_DATA, PH_CRC_HI, PH_CRC_LO})
            begin
                if (q_item.bus_error)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_BUS;
                    res_last   = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    case (phase_reg)
                        PH_POLL:
                        begin
                            if (q_item.is_token)
                                phase_next = PH_DATA;
                            else if (q_item.is_err_token)
                            begin
                                res_valid  = 1'b1;
                                res_status = q_item.err_status;
                                res_last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                poll_count_next = poll_inc;
                                if (poll_inc >= limit_eff)
                                begin
                                    res_valid  = 1'b1;
                                    res_status = ST_NORESP;
                                    res_last   = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            crc_next        = crc_update(crc_reg, q_item.rx_byte);
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == '0)
                                phase_next = PH_CRC_HI;
                            res_valid = 1'b1;
                            res_byte  = q_item.rx_byte;
                        end
                        PH_CRC_HI:
                        begin
                            crc_high_next = q_item.rx_byte;
                            phase_next    = PH_CRC_LO;
                        end
                        default:
                        begin
                            res_valid  = 1'b1;
                            res_last   = 1'b1;
                            res_status = ({crc_high_reg, q_item.rx_byte} == crc_reg) ? ST_OK
                                                                                    : ST_CRC;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            poll_count_reg <= '0;
            bytes_left_reg <= '0;
            crc_reg        <= 16'h0000;
            crc_high_reg   <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            poll_count_reg <= poll_count_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
            if (pop && res_valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && res_valid)
        begin
            out_byte_reg   <= res_byte;
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_status_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    `SDR_ASSERT_NEXT(a_crc_lo_ends, clk, rst_n, pop && q_item.op == OP_BYTE && phase_reg == PH_CRC_LO, out_valid_reg && out_last_reg && phase_reg == PH_IDLE)
    `SDR_ASSERT_NEXT(a_start_arms, clk, rst_n, pop && q_item.op == OP_START, phase_reg == PH_POLL && crc_reg == 16'h0000 && bytes_left_reg != '0)
    `SDR_ASSERT_IMPL(a_payload_ok, clk, rst_n, out_valid_reg && !out_last_reg, out_status_reg == ST_OK)

endmodule

@@ hdl/sd_spi_data_block_receiver.sv @@
// ---------------------------------------------------------------------------
// sd_spi_data_block_receiver
// sd card spi single block read: start token poll, payload, crc-16 check
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while the two-entry queue has room. An item
// goes into the queue on the cycle it is accepted and is executed by the
// read sequencer (byte-wide crc-16 update, token decode) once the output
// register is empty or being read; its result, if any, is registered there.
// A start item (tuser 0) arms a read; each byte item (tuser 1) is polled
// for the start token, then passed out as payload, then taken as crc bytes. The
// final status carries tlast. Configuration is taken at any time, one write per
// cycle, and must only change while no read is in flight.
module sd_spi_data_block_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // rx_byte[7:0], bus_error[8], zero fill
    input  logic        s_tuser,    // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // payload_byte[7:0], status[10:8], zero fill
    output logic        m_tlast,    // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import sdr_pkg::*;

    logic              q_valid;
    logic              q_ready;
    sdr_item_t         q_item;
    sdr_cfg_t          cfg;
    logic [LEN_W-1:0]  block_length_reg;
    logic [POLL_W-1:0] poll_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= LEN_W'(512);
            poll_limit_reg   <= POLL_W'(10);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BLOCK_LENGTH: block_length_reg <= cfg_data;
                CFG_POLL_LIMIT:   poll_limit_reg   <= cfg_data[POLL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.block_length = block_length_reg;
    assign cfg.poll_limit   = poll_limit_reg;

    sdr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    sdr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the sd spi data block receiver
// ---------------------------------------------------------------------------
// Drives read sequences into the slave stream (start items, token polling,
// payload bytes and crc bytes, with error tokens, bus errors and dropped reads
// mixed in), predicts every result from its own copy of the read state and
// compares each result on the master stream in order. Both streams idle at
// random. Register writes happen only between reads, once all results are in.
// ---------------------------------------------------------------------------
module testbench;

    import sdr_pkg::*;

    localparam int          STALL_LIMIT        = 1000;
    localparam int          MAX_GAP            = 18;
    localparam int          RESET_BLOCK_LENGTH = 512;
    localparam int          RESET_POLL_LIMIT   = 10;
    localparam logic [15:0] CRC16_POLY         = 16'h1021;
    localparam logic [7:0]  LOCK_BIT           = 8'h10;
    localparam logic [7:0]  PARAM_BIT          = 8'h08;
    localparam logic [1:0]  CFG_SPARE_2        = 2'd2;
    localparam logic [1:0]  CFG_SPARE_3        = 2'd3;

    typedef enum logic [2:0] {PH_IDLE, PH_POLL, PH_DATA, PH_CRC_HI, PH_CRC_LO} read_phase_t;

    typedef enum int {
        END_OK, END_BAD_CRC, END_BUS_DATA, END_BUS_CRC_HI, END_BUS_CRC_LO,
        END_ERR_TOKEN, END_BUS_POLL, END_NO_RESP, END_DROP_POLL, END_DROP_DATA
    } read_end_t;

    typedef struct packed {
        logic [7:0] payload;
        logic [2:0] status;
        logic       last;
    } block_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    // predicted read state and register copies
    logic [12:0]   blk_len_cfg  = 13'(RESET_BLOCK_LENGTH);
    logic [7:0]    poll_lim_cfg = 8'(RESET_POLL_LIMIT);
    read_phase_t   rd_phase     = PH_IDLE;
    logic [7:0]    polls        = '0;
    logic [12:0]   bytes_left   = '0;
    logic [15:0]   run_crc      = '0;
    logic [7:0]    crc_hi       = '0;
    block_result_t pending_results[$];

    bit src_gapless  = 1'b0;
    bit sink_gapless = 1'b0;

    int effective_items = 0;
    int items_sent      = 0;
    int reg_writes      = 0;
    int payload_seen    = 0;
    int reads_seen      = 0;
    int mismatches      = 0;
    logic [6:0] status_seen = '0;

    sd_spi_data_block_receiver dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        return c;
    endfunction

    function automatic int block_bytes();
        if (blk_len_cfg == 0)
            return 1;
        if (blk_len_cfg > MAX_BLOCK_BYTES)
            return MAX_BLOCK_BYTES;
        return int'(blk_len_cfg);
    endfunction

    function automatic int poll_bytes();
        return (poll_lim_cfg == 0) ? 1 : int'(poll_lim_cfg);
    endfunction

    // neither the start token nor an error token
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = START_TOKEN;
        while (b == START_TOKEN || (b & ~TOKEN_LOW_MASK) == 8'h00)
            b = 8'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] data_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return START_TOKEN;
            3: return {3'b000, 5'($urandom)};
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic end_read(input logic [2:0] st);
        pending_results.push_back('{8'h00, st, 1'b1});
        rd_phase = PH_IDLE;
    endtask

    task automatic predict_item(input logic op, input logic [7:0] b, input logic berr);
        if (op == OP_START)
        begin
            rd_phase   = PH_POLL;
            polls      = '0;
            bytes_left = 13'(block_bytes());
            run_crc    = '0;
            crc_hi     = '0;
            effective_items++;
            return;
        end
        if (rd_phase == PH_IDLE)
            return;
        effective_items++;
        if (berr)
        begin
            end_read(ST_BUS);
            return;
        end
        case (rd_phase)
            PH_POLL:
            begin
                if (b == START_TOKEN)
                    rd_phase = PH_DATA;
                else if ((b & ~TOKEN_LOW_MASK) == 8'h00)
                begin
                    if ((b & LOCK_BIT) != 0)
                        end_read(ST_LOCKED);
                    else if ((b & PARAM_BIT) != 0)
                        end_read(ST_PARAM);
                    else
                        end_read(ST_READ);
                end
                else
                begin
                    polls++;
                    if (polls >= poll_bytes())
                        end_read(ST_NORESP);
                end
            end
            PH_DATA:
            begin
                run_crc = crc16_byte(run_crc, b);
                if (bytes_left > 0)
                    bytes_left--;
                if (bytes_left == 0)
                    rd_phase = PH_CRC_HI;
                pending_results.push_back('{b, ST_OK, 1'b0});
            end
            PH_CRC_HI:
            begin
                crc_hi   = b;
                rd_phase = PH_CRC_LO;
            end
            default:
                end_read(({crc_hi, b} == run_crc) ? ST_OK : ST_CRC);
        endcase
    endtask

    task automatic send_item(input logic op, input logic [7:0] b, input logic berr);
        int gap;
        gap = src_gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, berr, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(op, b, berr);
        items_sent++;
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BLOCK_LENGTH)
            blk_len_cfg = val;
        else if (idx == CFG_POLL_LIMIT)
            poll_lim_cfg = val[7:0];
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic close_read();
        if (rd_phase != PH_IDLE)
            send_item(OP_BYTE, 8'($urandom), 1'b1);
    endtask

    task automatic configure(input logic [12:0] len, input logic [7:0] lim);
        close_read();
        settle();
        write_reg(CFG_BLOCK_LENGTH, len);
        write_reg(CFG_POLL_LIMIT, {5'($urandom), lim});
    endtask

    // one read from start item to the chosen ending, random content
    task automatic run_read(input int n_poll, input read_end_t how);
        int          len;
        int          cut;
        int          i;
        logic [15:0] crc;
        logic [7:0]  b;
        len = block_bytes();
        cut = $urandom_range(0, len - 1);
        crc = '0;
        src_gapless  = ($urandom_range(0, 5) == 0);
        sink_gapless = ($urandom_range(0, 5) == 0);
        send_item(OP_START, 8'($urandom), 1'($urandom));
        repeat (n_poll) send_item(OP_BYTE, filler_byte(), 1'b0);
        case (how)
            END_ERR_TOKEN:
            begin
                send_item(OP_BYTE, {3'b000, 5'($urandom)}, 1'b0);
                return;
            end
            END_BUS_POLL:
            begin
                send_item(OP_BYTE, 8'($urandom), 1'b1);
                return;
            end
            END_NO_RESP:
            begin
                repeat (poll_bytes() - n_poll) send_item(OP_BYTE, filler_byte(), 1'b0);
                return;
            end
            END_DROP_POLL:
                return;
            default:
                send_item(OP_BYTE, START_TOKEN, 1'b0);
        endcase
        for (i = 0; i < len; i++)
        begin
            if (i == cut && how == END_DROP_DATA)
                return;
            if (i == cut && how == END_BUS_DATA)
            begin
                send_item(OP_BYTE, 8'($urandom), 1'b1);
                return;
            end
            b   = data_byte();
            crc = crc16_byte(crc, b);
            send_item(OP_BYTE, b, 1'b0);
        end
        if (how == END_BUS_CRC_HI)
        begin
            send_item(OP_BYTE, crc[15:8], 1'b1);
            return;
        end
        if (how == END_BAD_CRC)
            crc = crc ^ 16'(1 << $urandom_range(0, 15));
        send_item(OP_BYTE, crc[15:8], 1'b0);
        send_item(OP_BYTE, crc[7:0], how == END_BUS_CRC_LO);
    endtask

    task automatic test_idle_bytes();
        send_item(OP_BYTE, START_TOKEN, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
    endtask

    task automatic test_error_tokens();
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h10, 1'b0);
        send_item(OP_START, 8'hFF, 1'b1);
        send_item(OP_BYTE, 8'h08, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h1F, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h07, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, START_TOKEN, 1'b1);
        // restart while polling, then run out the reset poll limit
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        repeat (RESET_POLL_LIMIT) send_item(OP_BYTE, 8'hFF, 1'b0);
    endtask

    task automatic test_reset_block_length();
        run_read(2, END_OK);
    endtask

    task automatic test_register_clamps();
        configure(13'd0, 8'd0);
        write_reg(CFG_SPARE_2, 13'h1FFF);
        write_reg(CFG_SPARE_3, 13'h0005);
        run_read(0, END_NO_RESP);
        run_read(0, END_OK);
        run_read(0, END_BAD_CRC);
        run_read(0, END_BUS_DATA);
        run_read(0, END_BUS_CRC_HI);
        run_read(0, END_BUS_CRC_LO);
        run_read(0, END_DROP_DATA);
        run_read(0, END_OK);
    endtask

    task automatic test_long_blocks();
        configure(13'd64, 8'd40);
        run_read(38, END_OK);
        run_read(0, END_NO_RESP);
    endtask

    task automatic test_random_reads();
        int        ph;
        int        target;
        int        n;
        int        lim;
        read_end_t how;
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: configure(13'd0, 8'd0);
                1: configure(13'd1, 8'd255);
                2: configure(13'd16, 8'd4);
                5: configure(13'd2, 8'd10);
                default: configure(13'($urandom_range(1, 40)), 8'($urandom_range(1, 20)));
            endcase
            lim    = poll_bytes();
            target = effective_items + 30;
            while (effective_items < target)
            begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 4))
                        send_item(($urandom_range(0, 3) != 0), 8'($urandom), 1'($urandom));
                case ($urandom_range(0, 19))
                    0: how = END_BAD_CRC;
                    1: how = END_BUS_DATA;
                    2: how = END_BUS_CRC_HI;
                    3: how = END_BUS_CRC_LO;
                    4: how = END_ERR_TOKEN;
                    5: how = END_BUS_POLL;
                    6: how = (lim > 24) ? END_OK : END_NO_RESP;
                    7: how = END_DROP_POLL;
                    8: how = END_DROP_DATA;
                    default: how = END_OK;
                endcase
                n = $urandom_range(0, (lim - 1 < 5) ? lim - 1 : 5);
                run_read(n, how);
            end
        end
    endtask

    task automatic report_miss(input string what);
        if (mismatches < 10)
            $display("%t mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        block_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_miss($sformatf("unexpected result data %h status %0d last %b",
                                      m_tdata[7:0], m_tdata[10:8], m_tlast));
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.payload || m_tdata[10:8] !== want.status ||
                    m_tlast !== want.last)
                    report_miss($sformatf(
                        "expected data %h status %0d last %b, got data %h status %0d last %b",
                        want.payload, want.status, want.last,
                        m_tdata[7:0], m_tdata[10:8], m_tlast));
            end
            if (m_tlast === 1'b1)
            begin
                reads_seen++;
                if (m_tdata[10:8] <= ST_BUS)
                    status_seen[m_tdata[10:8]] = 1'b1;
            end
            else
                payload_seen++;
        end
    end

    // result side stalls
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = sink_gapless ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    // watchdog on cycles without any accepted item, taken result or register write
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_error_tokens();
        test_reset_block_length();
        test_register_clamps();
        test_long_blocks();
        test_random_reads();
        settle();

        $display("run covered %0d items, %0d payload bytes and %0d finished reads",
                 items_sent, payload_seen, reads_seen);
        $display("register writes %0d, final status codes seen (one bit per code) %b",
                 reg_writes, status_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
